FILE: hdl/bis_pkg.sv
`default_nettype none

package bis_pkg;

  // Store geometry (each bound is a power of two)
  localparam int MAX_WIDTH    = 128;
  localparam int MAX_HEIGHT   = 128;
  localparam int MAX_CHANNELS = 4;
  localparam int FRAC_BITS    = 8;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ADDR_W = ROW_W + COL_W + CH_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int IDX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;

  // Port field widths
  localparam int PIX_W    = 7;
  localparam int PCH_W    = 2;
  localparam int SAMPLE_W = 16;
  localparam int COORD_W  = 20;
  localparam int VALUE_W  = 26;
  localparam int REG_W    = 8;
  localparam int CNT_W    = 3;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // Datapath widths
  localparam int IP_W   = COORD_W - FRAC_BITS;     // integer part of a coordinate
  localparam int CMP_W  = IP_W + 1;                // integer part plus one
  localparam int FR_W   = FRAC_BITS + 1;           // signed fraction
  localparam int WGT_W  = FRAC_BITS + 2;           // signed 1-D weight
  localparam int WT_W   = 2 * WGT_W;               // signed 2-D weight
  localparam int PROD_W = SAMPLE_W + 1 + WT_W;     // sample times weight
  localparam int ACC_W  = PROD_W + 2;              // sum of four products

  // Register map (word index)
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [REG_W-1:0] WIDTH_RST  = REG_W'(128);
  localparam logic [REG_W-1:0] HEIGHT_RST = REG_W'(128);
  localparam logic [CNT_W-1:0] COUNT_RST  = CNT_W'(1);

  // Neighbor order: top-left, top-right, bottom-left, bottom-right
  localparam logic [1:0] NB_FIRST = 2'd0;
  localparam logic [1:0] NB_LAST  = 2'd3;

  // Tag that follows each store read down the pipeline
  typedef struct packed {
    logic [1:0]      nb;
    logic [CH_W-1:0] ch;
    logic            last;
  } tap_tag_t;

endpackage

`default_nettype wire

FILE: hdl/bilinear_image_sampler.sv
// A query's results come out one per channel, after the reads pass the store read register,
// the product register, the accumulator and the output register; a sample write gives no result.
// A query holds the command channel until the last of the four reads per channel on the single
// port of the sample store is issued; the whole read pipe stalls on a held result.
// Reset: control state and registers return to 128x128, one channel; the sample store
// is not cleared and holds garbage until written.
`default_nettype none

module bilinear_image_sampler import bis_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  // command channel
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  logic                       command,
  input  logic [PIX_W-1:0]           pixel_col,
  input  logic [PIX_W-1:0]           pixel_row,
  input  logic [PCH_W-1:0]           pixel_channel,
  input  logic [SAMPLE_W-1:0]        sample_value,
  input  logic signed [COORD_W-1:0]  query_x,
  input  logic signed [COORD_W-1:0]  query_y,
  // result channel
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [PCH_W-1:0]           out_channel,
  output logic signed [VALUE_W-1:0]  interp_value,
  output logic                       last_channel,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready
);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_READ} state_t;

  localparam logic signed [WGT_W-1:0] ONE_W    = WGT_W'(1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] HALF_A   = ACC_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] VAL_MAX_A = ACC_W'((1 << (VALUE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] VAL_MIN_A = ACC_W'(-(1 << (VALUE_W - 1)));

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;
  logic [CNT_W-1:0] channel_count;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RST;
      image_height  <= HEIGHT_RST;
      channel_count <= COUNT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:   image_width   <= pwdata[REG_W-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= pwdata[REG_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:   prdata = PDATA_W'(image_width);
      REG_IMAGE_HEIGHT:  prdata = PDATA_W'(image_height);
      REG_CHANNEL_COUNT: prdata = PDATA_W'(channel_count);
      default:           prdata = '0;
    endcase
  end

  // Effective bound minus one: zero reads as one, too large reads as the store bound
  function automatic logic [IDX_W-1:0] eff_m1(input logic [REG_W-1:0] v, input int bound);
    if (v == '0) return '0;
    else if (32'(v) > bound) return IDX_W'(bound - 1);
    else return IDX_W'(32'(v) - 32'd1);
  endfunction

  // Clamp a signed index to 0..hi
  function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [CMP_W-1:0] v,
                                                 input logic [IDX_W-1:0] hi);
    if (v < 0) return '0;
    else if (v > $signed({{(CMP_W-IDX_W){1'b0}}, hi})) return hi;
    else return v[IDX_W-1:0];
  endfunction

  logic [IDX_W-1:0] wm1, hm1;
  logic [CH_W-1:0]  pdm1;

  always_comb begin
    wm1 = eff_m1(image_width, MAX_WIDTH);
    hm1 = eff_m1(image_height, MAX_HEIGHT);
    if (channel_count == '0)
      pdm1 = '0;
    else if (32'(channel_count) > MAX_CHANNELS)
      pdm1 = CH_W'(MAX_CHANNELS - 1);
    else
      pdm1 = CH_W'(32'(channel_count) - 32'd1);
  end

  // ---------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------
  state_t state;
  logic   cmd_fire, adv, issue;
  logic [1:0]      nb;
  logic [CH_W-1:0] ch;
  logic            ch_last;

  assign cmd_ready = (state == S_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign adv       = !res_valid || res_ready;   // whole read pipe stalls on a held result
  assign issue     = (state == S_READ) && adv;
  assign ch_last   = (ch == pdm1);

  // ---------------------------------------------------------------
  // Coordinate split: truncate toward zero, signed fraction
  // ---------------------------------------------------------------
  logic signed [COORD_W-1:0] qx_q, qy_q;
  logic                      adj_x, adj_y;
  logic signed [IP_W-1:0]    ip_x, ip_y;
  logic signed [CMP_W-1:0]   ip1_x, ip1_y;
  logic signed [FR_W-1:0]    fx, fy;
  logic signed [WGT_W-1:0]   wx0, wy0;

  always_comb begin
    adj_x = qx_q[COORD_W-1] && (qx_q[FRAC_BITS-1:0] != '0);
    adj_y = qy_q[COORD_W-1] && (qy_q[FRAC_BITS-1:0] != '0);
    ip_x  = qx_q[COORD_W-1:FRAC_BITS] + {{(IP_W-1){1'b0}}, adj_x};
    ip_y  = qy_q[COORD_W-1:FRAC_BITS] + {{(IP_W-1){1'b0}}, adj_y};
    ip1_x = CMP_W'(ip_x) + CMP_W'(1);
    ip1_y = CMP_W'(ip_y) + CMP_W'(1);
    fx    = {adj_x, qx_q[FRAC_BITS-1:0]};
    fy    = {adj_y, qy_q[FRAC_BITS-1:0]};
    wx0   = ONE_W - WGT_W'(fx);
    wy0   = ONE_W - WGT_W'(fy);
  end

  logic [COL_W-1:0]        col0, col1;
  logic [ROW_W-1:0]        row0, row1;
  logic signed [FR_W-1:0]  fx_q, fy_q;
  logic signed [WGT_W-1:0] wx0_q, wy0_q;

  // State machine and read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nb    <= NB_FIRST;
      ch    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_fire && command) begin
            qx_q  <= query_x;
            qy_q  <= query_y;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          col0  <= COL_W'(clamp_idx(CMP_W'(ip_x), wm1));
          col1  <= COL_W'(clamp_idx(ip1_x, wm1));
          row0  <= ROW_W'(clamp_idx(CMP_W'(ip_y), hm1));
          row1  <= ROW_W'(clamp_idx(ip1_y, hm1));
          fx_q  <= fx;
          fy_q  <= fy;
          wx0_q <= wx0;
          wy0_q <= wy0;
          nb    <= NB_FIRST;
          ch    <= '0;
          state <= S_READ;
        end
        S_READ: begin
          if (adv) begin
            nb <= nb + 2'd1;
            if (nb == NB_LAST) begin
              ch <= ch + CH_W'(1);
              if (ch_last) state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Sample store, single port
  // ---------------------------------------------------------------
  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata;
  logic [ADDR_W-1:0]   wr_addr, rd_addr, mem_addr;
  logic                wr_in_range, mem_we;

  assign wr_in_range = (32'(pixel_col) < MAX_WIDTH) && (32'(pixel_row) < MAX_HEIGHT)
                    && (32'(pixel_channel) < MAX_CHANNELS);
  assign wr_addr  = {ROW_W'(pixel_row), COL_W'(pixel_col), CH_W'(pixel_channel)};
  assign rd_addr  = {(nb[1] ? row1 : row0), (nb[0] ? col1 : col0), ch};
  assign mem_we   = cmd_fire && !command && wr_in_range;
  assign mem_addr = (state == S_READ) ? rd_addr : wr_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= sample_value;
    if (issue)  rdata <= mem[mem_addr];
  end

  // ---------------------------------------------------------------
  // Weight, multiply, accumulate, round
  // ---------------------------------------------------------------
  logic signed [WGT_W-1:0]  wxsel, wysel;
  logic signed [WT_W-1:0]   wt1;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, rnd, shr;
  logic [VALUE_W-1:0]       sat_value;
  tap_tag_t                 tag1, tag2, tag3;
  logic                     v1, v2, done3;

  assign wxsel = nb[0] ? WGT_W'(fx_q) : wx0_q;
  assign wysel = nb[1] ? WGT_W'(fy_q) : wy0_q;

  always_comb begin
    rnd = acc + HALF_A;
    shr = rnd >>> FRAC_BITS;
    if (shr > VAL_MAX_A)
      sat_value = VAL_MAX_A[VALUE_W-1:0];
    else if (shr < VAL_MIN_A)
      sat_value = VAL_MIN_A[VALUE_W-1:0];
    else
      sat_value = shr[VALUE_W-1:0];
  end

  // Pipe valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      done3     <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1        <= issue;
      v2        <= v1;
      done3     <= v2 && (tag2.nb == NB_LAST);
      res_valid <= done3;
    end
  end

  // Pipe payload
  always_ff @(posedge clk) begin
    if (adv) begin
      tag1 <= '{nb: nb, ch: ch, last: ch_last};
      wt1  <= wxsel * wysel;
      tag2 <= tag1;
      prod <= $signed({1'b0, rdata}) * wt1;
      tag3 <= tag2;
      if (v2) begin
        if (tag2.nb == NB_FIRST) acc <= ACC_W'(prod);
        else                     acc <= acc + ACC_W'(prod);
      end
      if (done3) begin
        out_channel  <= PCH_W'(tag3.ch);
        interp_value <= sat_value;
        last_channel <= tag3.last;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bis_checker.sv
`default_nettype none

module bis_checker import bis_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [PCH_W-1:0]          out_channel,
  input logic signed [VALUE_W-1:0] interp_value,
  input logic                      last_channel
);

  // no result pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_channel)
      && $stable(interp_value) && $stable(last_channel))
    else $error("stalled result changed");

  // channels of one query come out in order
  a_chan_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !last_channel
      |=> !res_valid || (out_channel == PCH_W'($past(out_channel) + 1'b1)))
    else $error("channel out of order");

  // the top channel always closes a query
  a_top_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (out_channel == PCH_W'(MAX_CHANNELS - 1)) |-> last_channel)
    else $error("top channel without last mark");

endmodule

bind bilinear_image_sampler bis_checker u_bis_checker (.*);

`default_nettype wire
